[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  // Default queue depth and fixed field widths
  localparam int QUEUE_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int OCC_W       = 7;

  // Command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // One request item
  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
  } req_t;

  // One response item
  typedef struct packed {
    logic signed [DATA_W-1:0] head_value;
    logic                     head_valid;
    logic                     empty_error;
    logic                     full_error;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // One stored queue entry
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted request
    logic rd_head;     // read the head entry
    logic rd_last;     // read the last entry, start the walk
    logic rd_prev;     // read the entry before the current one
    logic wr_shift;    // move the entry just read one place back
    logic wr_item;     // write the held item
    logic slot_zero;   // item goes to the head slot, else behind the current entry
    logic pop;         // return the head and drop it
    logic push;        // count the inserted item
    logic err_empty;   // report dequeue on empty queue
    logic err_full;    // report enqueue on full queue
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_deq;
    logic empty;
    logic full;
    logic move;        // entry just read must move back for the held item
    logic idx_zero;    // entry just read is the head
    logic res_free;    // response register can take a new item
  } status_t;

endpackage

[rtl/spq_if.sv]
`timescale 1ns / 1ps

// Request channel
interface spq_req_if;
  logic          valid;
  logic          ready;
  spq_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Response channel
interface spq_rsp_if;
  logic          valid;
  logic          ready;
  spq_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/spq_ram.sv]
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/spq_datapath.sv]
`timescale 1ns / 1ps

module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  spq_pkg::ctrl_t   ctrl,
  output spq_pkg::status_t status,
  input  spq_pkg::req_t    req_payload,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output spq_pkg::rsp_t    rsp_payload
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  spq_pkg::req_t   held;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  spq_pkg::entry_t rd_entry;
  spq_pkg::entry_t wr_entry;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] idx_up;
  logic [IDX_W-1:0] idx_down;
  logic [IDX_W-1:0] last_idx;
  logic             rsp_load;

  // Map a position counted from the head onto the ring buffer
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign idx_up   = idx + 1'b1;
  assign idx_down = idx - 1'b1;
  assign last_idx = IDX_W'(count - 1'b1);

  // Select read and write addresses
  always_comb begin
    rd_en = ctrl.rd_head | ctrl.rd_last | ctrl.rd_prev;
    if (ctrl.rd_last) begin
      rd_addr = phys(last_idx);
    end else if (ctrl.rd_prev) begin
      rd_addr = phys(idx_down);
    end else begin
      rd_addr = phys('0);
    end

    wr_en = ctrl.wr_shift | ctrl.wr_item;
    if (ctrl.wr_item && ctrl.slot_zero) begin
      wr_addr = phys('0);
    end else begin
      wr_addr = phys(idx_up);
    end
    if (ctrl.wr_shift) begin
      wr_entry = rd_entry;
    end else begin
      wr_entry.value = held.item_value;
      wr_entry.prio  = held.item_priority;
    end
  end

  spq_ram #(
    .WIDTH ($bits(spq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // Report status; the new item passes equal priorities except at the head
  always_comb begin
    status.is_deq   = (held.command == spq_pkg::CMD_DEQUEUE);
    status.empty    = (count == '0);
    status.full     = (count == DEPTH_C);
    status.idx_zero = (idx == '0);
    if (idx == '0) begin
      status.move = ($signed(rd_entry.prio) < $signed(held.item_priority));
    end else begin
      status.move = ($signed(rd_entry.prio) <= $signed(held.item_priority));
    end
    status.res_free = !rsp_valid || rsp_ready;
  end

  assign rsp_load = ctrl.pop | ctrl.push | ctrl.err_empty | ctrl.err_full;

  // Hold the request, walk index, ring pointer and fill count
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      held <= req_payload;
    end
    if (ctrl.rd_last) begin
      idx <= last_idx;
    end else if (ctrl.rd_prev) begin
      idx <= idx_down;
    end
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head  <= phys(IDX_W'(1));
        count <= count - 1'b1;
      end else if (ctrl.push) begin
        count <= count + 1'b1;
      end
    end
  end

  // Load and drain the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp_payload.head_value  <= ctrl.pop ? rd_entry.value : '0;
      rsp_payload.head_valid  <= ctrl.pop;
      rsp_payload.empty_error <= ctrl.err_empty;
      rsp_payload.full_error  <= ctrl.err_full;
      if (ctrl.pop) begin
        rsp_payload.occupancy <= spq_pkg::OCC_W'(count - 1'b1);
      end else if (ctrl.push) begin
        rsp_payload.occupancy <= spq_pkg::OCC_W'(count + 1'b1);
      end else begin
        rsp_payload.occupancy <= spq_pkg::OCC_W'(count);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("fill count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> count != '0) else $error("pop from empty queue");
  a_push_notfull: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> count != DEPTH_C) else $error("push into full queue");
  a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && rsp_valid) |-> rsp_ready) else $error("response overwritten");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.wr_shift && ctrl.wr_item)) else $error("two writes in one cycle");
`endif

endmodule

[rtl/spq_ctrl.sv]
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  spq_pkg::status_t status,
  output spq_pkg::ctrl_t   ctrl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_WALK,
    S_PLACE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE) && status.res_free;

  // Decode commands and next state
  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          ctrl.capture = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.is_deq) begin
          if (status.empty) begin
            ctrl.err_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            ctrl.rd_head = 1'b1;
            state_next   = S_POP;
          end
        end else if (status.full) begin
          ctrl.err_full = 1'b1;
          state_next    = S_IDLE;
        end else if (status.empty) begin
          ctrl.wr_item   = 1'b1;
          ctrl.slot_zero = 1'b1;
          ctrl.push      = 1'b1;
          state_next     = S_IDLE;
        end else begin
          ctrl.rd_last = 1'b1;
          state_next   = S_WALK;
        end
      end
      S_POP: begin
        ctrl.pop   = 1'b1;
        state_next = S_IDLE;
      end
      S_WALK: begin
        if (status.move) begin
          ctrl.wr_shift = 1'b1;
          if (status.idx_zero) begin
            state_next = S_PLACE;
          end else begin
            ctrl.rd_prev = 1'b1;
          end
        end else begin
          ctrl.wr_item = 1'b1;
          ctrl.push    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_PLACE: begin
        ctrl.wr_item   = 1'b1;
        ctrl.slot_zero = 1'b1;
        ctrl.push      = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_capture_dispatch: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |=> state == S_DISPATCH) else $error("capture without dispatch");
  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> $past(ctrl.rd_head)) else $error("pop without head read");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == S_IDLE) else $error("ready while busy");
`endif

endmodule

[rtl/sorted_priority_queue.sv]
`timescale 1ns / 1ps

// Bounded priority queue kept in descending priority order.
// req channel: command (enqueue or dequeue), item_value and item_priority.
// rsp channel: one item per request with head_value, head_valid,
// empty_error, full_error and the occupancy after the request.
// Entries live in a ring buffer RAM; a dequeue advances the head pointer,
// an enqueue walks from the tail toward the head one entry per cycle,
// moving each entry back a place until the slot for the new item is found.
// Steps from acceptance to the response register:
//   errors and enqueue into an empty queue: answered in dispatch
//   dequeue: dispatch reads the head from the RAM, pop returns it
//   enqueue: dispatch reads the tail, walk shifts (place writes slot 0)
// One request is in work at a time; the next is taken in the cycle after
// its response is loaded, so the RAM walk sets the rate.
// When rsp is stalled, the response waits in its register and req stays
// not ready until it is taken. Reset empties the queue; no clearing pass
// is needed.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  spq_pkg::ctrl_t   ctrl;
  spq_pkg::status_t status;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .req_payload (req.payload),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
  );

endmodule
